// ===== hdl/lrr_pkg.sv =====
`default_nettype none

package lrr_pkg;

    localparam int unsigned DefListDepth = 64;

    localparam logic [31:0] LcgMul     = 32'd472940017;
    localparam logic [31:0] LcgAdd     = 32'd832416023;
    localparam logic [31:0] StateReset = 32'd1489853723;

    // action codes
    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_SEED  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_LOWER = 2'd0;
    localparam logic [1:0] REG_UPPER = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        seed_value;
        logic [5:0]         entry_index;
        logic signed [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        state_after;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load_seed;
        logic write_entry;
        logic advance;
        logic map;
        logic mul;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== hdl/lrr_ctrl.sv =====
`default_nettype none

module lrr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_action,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lrr_pkg::t_dp_cmd   o_cmd
);
    import lrr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                // take nothing while reset is held
                if (i_in_valid && i_rst_n) begin
                    unique case (i_action)
                        ACT_DRAW: begin
                            o_cmd.advance = 1'b1;
                            n_state       = ST_MAP;
                        end
                        ACT_SEED:  o_cmd.load_seed   = 1'b1;
                        ACT_WRITE: o_cmd.write_entry = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = !i_rst_n || (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/lrr_dpath.sv =====
`default_nettype none

module lrr_dpath #(
    parameter int unsigned LIST_DEPTH = lrr_pkg::DefListDepth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire lrr_pkg::t_in_item  i_in_data,
    input  wire lrr_pkg::t_dp_cmd   i_cmd,
    output lrr_pkg::t_out_item      o_out_data
);
    import lrr_pkg::*;

    localparam int unsigned AW = $clog2(LIST_DEPTH);
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic [6:0]         r_count;
    logic [31:0]        r_gen_state;

    logic [31:0]        mem [LIST_DEPTH];
    logic [31:0]        r_rd_data;

    logic signed [33:0] r_base;
    logic [32:0]        r_mag;
    logic               r_neg;
    logic [AW-1:0]      r_idx;
    logic [63:0]        r_prod;
    t_out_item          r_out;

    // span and bias from the bounds
    logic signed [33:0] lo_w, hi_w, diff, span, n_base;
    logic               below;
    logic [33:0]        span_abs;

    // list index
    logic [CW-1:0]      cnt;
    logic [CW+31:0]     idx_prod;
    logic [CW-1:0]      idx_full;
    logic [AW-1:0]      n_idx;

    // product and final value
    logic [63:0]        n_prod;
    logic [32:0]        q_inc;
    logic signed [33:0] scaled, range_val;
    logic [31:0]        wr_idx32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower     <= '0;
            r_upper     <= 32'sd1;
            r_count     <= '0;
            r_gen_state <= StateReset;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LOWER: r_lower <= i_cfg_data;
                    REG_UPPER: r_upper <= i_cfg_data;
                    REG_COUNT: r_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_seed) begin
                r_gen_state <= i_in_data.seed_value;
            end else if (i_cmd.advance) begin
                r_gen_state <= r_gen_state * LcgMul + LcgAdd;
            end
        end
    end

    always_comb begin
        lo_w  = 34'(r_lower);
        hi_w  = 34'(r_upper);
        diff  = hi_w - lo_w;
        below = diff[33];
        if (r_count > 7'd1) begin
            span = below ? diff - 34'sd1 : diff + 34'sd1;
        end else begin
            span = (diff != 34'sd0) ? diff : 34'sd1;
        end
        span_abs = span[33] ? 34'(-span) : 34'(span);
        n_base   = lo_w + 34'(below);

        if (32'(r_count) > LIST_DEPTH) begin
            cnt = CW'(LIST_DEPTH);
        end else begin
            cnt = CW'(r_count);
        end
        idx_prod = (CW + 32)'(cnt) * (CW + 32)'(r_gen_state);
        idx_full = idx_prod[CW+31:32];
        if (32'(idx_full) >= LIST_DEPTH) begin
            n_idx = AW'(LIST_DEPTH - 1);
        end else begin
            n_idx = idx_full[AW-1:0];
        end
    end

    // magnitude above 2^32 - 1 is exactly 2^32, whose low word is zero
    assign n_prod = 64'(r_mag[31:0]) * 64'(r_gen_state)
                  + (r_mag[32] ? {r_gen_state, 32'd0} : 64'd0);

    always_comb begin
        q_inc     = 33'(r_prod[63:32]) + 33'(r_neg && (r_prod[31:0] != 32'd0));
        scaled    = r_neg ? -34'(q_inc) : 34'(q_inc);
        range_val = r_base + scaled;
    end

    assign wr_idx32 = 32'(i_in_data.entry_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && (wr_idx32 < LIST_DEPTH)) begin
            mem[wr_idx32[AW-1:0]] <= i_in_data.entry_value;
        end
        if (i_cmd.mul) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            r_base <= n_base;
            r_mag  <= span_abs[32:0];
            r_neg  <= span[33];
            r_idx  <= n_idx;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.finish) begin
            r_out.value       <= (r_count > 7'd2) ? r_rd_data : range_val[31:0];
            r_out.state_after <= r_gen_state;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== hdl/lcg_ranged_random_core.sv =====
`default_nettype none

// Ranged pseudo-random generator on a 32-bit linear congruential state
// (state = state * 472940017 + 832416023 mod 2^32, reset 1489853723).
// An input transfer carries an action: draw, load seed, or write one word of
// the choice list. Only a draw produces an output transfer, carrying the
// mapped value and the new state. arg_count 0 or 1 draws from
// [lower_bound, upper_bound), 2 from [lower_bound, upper_bound], either order
// of bounds allowed; 3 or more picks list entry floor(min(count, depth) *
// state / 2^32). Entries must be written before they are drawn.
// Seed and write actions take effect on their input transfer; unknown
// actions are ignored. A draw goes from input transfer to output register
// in these steps: advance the state, form span and list index, run the span
// multiply and the registered list read, then finish the add. The input
// stalls during the map, multiply and finish steps, and longer while an
// earlier result still waits in the output register. The draw path is set
// by a chain of two dependent multiplies. The input also stalls while reset
// is held. The output register lets the next input transfer proceed while
// a result waits to be taken. Configuration is written by the user through
// a plain write port (index 0 lower_bound, 1 upper_bound, 2 arg_count) while
// the block is idle; the block itself does not enforce this.
module lcg_ranged_random_core #(
    parameter int unsigned LIST_DEPTH = lrr_pkg::DefListDepth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire lrr_pkg::t_in_item  i_in_data,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output lrr_pkg::t_out_item      o_out_data
);
    import lrr_pkg::*;

    t_dp_cmd cmd;

    // sequence each transfer: decode action, step the draw stages
    lrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // hold state, configuration and list; compute the mapped value
    lrr_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sim/lrr_draw_checker.sv =====
`default_nettype none

// Watches both channels and the configuration port of the generator, keeps
// its own copy of the state, ranges and choice list, and compares every
// output transfer with the oldest predicted draw.
module lrr_draw_checker #(
    parameter int unsigned LIST_DEPTH = lrr_pkg::DefListDepth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire lrr_pkg::t_in_item  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire lrr_pkg::t_out_item i_out_data,
    output int                      o_fail_count,
    output int                      o_pending
);
    import lrr_pkg::*;

    logic [31:0]        gen_state;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [6:0]         arg_count;
    logic [31:0]        list_words [LIST_DEPTH];
    t_out_item          expected_draws [$];
    int                 fail_count = 0;

    always @(posedge i_clk) begin : watch
        logic signed [63:0] lo64;
        logic signed [63:0] up64;
        logic signed [63:0] d64;
        logic signed [63:0] span64;
        logic signed [65:0] prod;
        logic signed [63:0] scaled;
        logic signed [63:0] sum;
        logic [63:0]        idx64;
        logic [31:0]        nxt;
        logic               neg;
        int                 cnt;
        t_out_item          want;
        t_out_item          got;

        if (!i_rst_n) begin
            gen_state   = StateReset;
            lower_bound = 32'sd0;
            upper_bound = 32'sd1;
            arg_count   = 7'd0;
            for (int k = 0; k < LIST_DEPTH; k++) list_words[k] = 32'd0;
            expected_draws.delete();
        end else begin
            // retire first: a result leaving now never belongs to an item arriving now
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_draws.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing pending: value %0d state %h",
                             $time, got.value, got.state_after);
                end else begin
                    want = expected_draws.pop_front();
                    if (got.value !== want.value) begin
                        fail_count++;
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want.value, got.value);
                    end
                    if (got.state_after !== want.state_after) begin
                        fail_count++;
                        $display("%0t: state_after mismatch: expected %h, actual %h",
                                 $time, want.state_after, got.state_after);
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LOWER: lower_bound = i_cfg_data;
                    REG_UPPER: upper_bound = i_cfg_data;
                    REG_COUNT: arg_count   = i_cfg_data[6:0];
                    default:   ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.action)
                    ACT_SEED: gen_state = i_in_data.seed_value;
                    ACT_WRITE: begin
                        if (i_in_data.entry_index < LIST_DEPTH)
                            list_words[i_in_data.entry_index] = i_in_data.entry_value;
                    end
                    ACT_DRAW: begin
                        nxt       = gen_state * LcgMul + LcgAdd;
                        gen_state = nxt;
                        if (arg_count < 7'd3) begin
                            // form the bound difference wide so it cannot wrap
                            lo64 = 64'(lower_bound);
                            up64 = 64'(upper_bound);
                            d64  = up64 - lo64;
                            neg  = d64 < 0;
                            if (arg_count > 7'd1)
                                span64 = neg ? d64 - 64'sd1 : d64 + 64'sd1;
                            else
                                span64 = (d64 != 0) ? d64 : 64'sd1;
                            // arithmetic shift of the exact product is the floor
                            prod   = 66'(span64) * $signed({34'd0, nxt});
                            scaled = 64'(prod >>> 32);
                            sum    = lo64 + scaled + (neg ? 64'sd1 : 64'sd0);
                            want.value = sum[31:0];
                        end else begin
                            cnt   = (arg_count > LIST_DEPTH) ? int'(LIST_DEPTH)
                                                             : int'(arg_count);
                            idx64 = (64'(cnt) * {32'd0, nxt}) >> 32;
                            if (idx64 >= LIST_DEPTH) idx64 = 64'(LIST_DEPTH - 1);
                            want.value = list_words[int'(idx64)];
                        end
                        want.state_after = nxt;
                        expected_draws.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_draws.size();
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

// ===== sim/lcg_ranged_random_core_test.sv =====
`default_nettype none

// Stimulus and verdict for the ranged generator. The checker beside the block
// does all prediction; this module only produces transfers, configuration
// writes and backpressure, then decides pass or fail.
module lcg_ranged_random_core_test;
    import lrr_pkg::*;

    localparam int          ItemGoal    = 1950;
    localparam int          DrainCycles = 12;     // block latency plus margin
    localparam int          HoldCycles  = 400;    // long receiver hold-off
    localparam int          TimeLimit   = 2000000;
    localparam logic [1:0]  ActIgnored  = 2'd3;   // unknown action, no result

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = REG_LOWER;
    logic [31:0] cfg_data = 32'd0;
    logic       in_valid  = 1'b0;
    t_in_item   in_data   = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    int         fail_count;
    int         pending;

    bit         hold_go   = 1'b0;
    bit         hold_done = 1'b0;
    int         burst_left = 0;
    int         items_sent = 0;
    bit [63:0]  entry_loaded = '0;

    lcg_ranged_random_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    lrr_draw_checker draw_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result.
    initial begin
        #TimeLimit;
        $display("Test completed with failures");
        $finish;
    end

    // Build an item with every field random, then pin the action.
    function automatic t_in_item any_item(input logic [1:0] act);
        t_in_item item;
        item.action      = act;
        item.seed_value  = $urandom();
        item.entry_index = 6'($urandom_range(0, 63));
        item.entry_value = $urandom();
        return item;
    endfunction

    // Present one item and hold it until the block takes it. Valid is left
    // high so a following item does not toggle it within the same step.
    task automatic send_item(input t_in_item item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    // Sender pacing: bursts of random length, separated by random gaps
    // (sometimes none, which gives back-to-back stretches).
    task automatic offer_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (item.action == ACT_WRITE) entry_loaded[item.entry_index] = 1'b1;
        items_sent++;
        send_item(item);
    endtask

    task automatic offer_seed(input logic [31:0] seed);
        t_in_item item;
        item = any_item(ACT_SEED);
        item.seed_value = seed;
        offer_item(item);
    endtask

    task automatic offer_write(input int idx, input logic [31:0] word);
        t_in_item item;
        item = any_item(ACT_WRITE);
        item.entry_index = 6'(idx);
        item.entry_value = word;
        offer_item(item);
    endtask

    // Drop valid and wait for every predicted draw to come out, then let the
    // block finish any seed or write still in flight.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; only legal when idle.
    task automatic set_ranges(input logic [31:0] lo, input logic [31:0] up,
                              input logic [6:0] cnt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOWER;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_UPPER;
        cfg_data  <= up;
        @(posedge clk);
        cfg_index <= REG_COUNT;
        cfg_data  <= {25'd0, cnt};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Make sure every entry a list draw can pick has been written.
    task automatic fill_list(input int cnt);
        for (int k = 0; k < cnt && k < 64; k++)
            if (!entry_loaded[k]) offer_write(k, $urandom());
    endtask

    // Receiver: stall on segments of changing pattern, and once hold off
    // for a long stretch while the sender keeps offering items.
    initial begin : receiver
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(5, 80);
                end
                seg_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 25);
                    2:       out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int                 mode;
        int                 n;
        int                 r;
        logic signed [31:0] lo;
        logic signed [31:0] up;
        logic [6:0]         cnt;
        t_in_item           item;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // reset ranges [0, 1): every draw gives zero
        offer_item(any_item(ACT_DRAW));
        offer_item(any_item(ACT_DRAW));
        // state extremes
        offer_seed(32'h0000_0000);
        offer_item(any_item(ACT_DRAW));
        offer_seed(32'hFFFF_FFFF);
        offer_item(any_item(ACT_DRAW));
        // unknown action: ignored, no result
        offer_item(any_item(ActIgnored));
        // list words at the index and value extremes
        offer_write(0, 32'h8000_0000);
        offer_write(63, 32'h7FFF_FFFF);
        offer_write(1, 32'hFFFF_FFFF);
        offer_write(2, 32'h0000_0000);
        drain();

        // empty span: result is the lower bound
        set_ranges(32'sd5, 32'sd5, 7'd0);
        offer_item(any_item(ACT_DRAW));
        offer_item(any_item(ACT_DRAW));
        drain();

        // widest inclusive span, top of state range
        set_ranges(32'h8000_0000, 32'h7FFF_FFFF, 7'd2);
        offer_seed(32'hFFFF_FFFF);
        offer_item(any_item(ACT_DRAW));
        offer_item(any_item(ACT_DRAW));
        drain();

        // reversed bounds, exclusive then inclusive
        set_ranges(32'h7FFF_FFFF, 32'h8000_0000, 7'd1);
        offer_item(any_item(ACT_DRAW));
        drain();
        set_ranges(32'h7FFF_FFFF, 32'h8000_0000, 7'd2);
        offer_item(any_item(ACT_DRAW));
        drain();

        // shortest list
        set_ranges(32'sd0, 32'sd1, 7'd3);
        offer_item(any_item(ACT_DRAW));
        offer_item(any_item(ACT_DRAW));
        drain();

        // ---- random part ----
        hold_go = 1'b1;
        while (items_sent < ItemGoal) begin
            mode = $urandom_range(0, 9);
            lo   = $urandom();
            up   = $urandom();
            cnt  = 7'($urandom_range(0, 2));
            case (mode)
                0: begin
                    lo = 32'h8000_0000;
                    up = 32'h7FFF_FFFF;
                end
                1: begin
                    lo = 32'h7FFF_FFFF;
                    up = 32'h8000_0000;
                end
                2: up = lo;
                3: begin
                    lo = $urandom_range(0, 2000) - 1000;
                    up = lo + $urandom_range(0, 8) - 4;
                end
                7: cnt = 7'd3;
                // full list, or a count above the list depth
                8: cnt = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
                9: cnt = 7'($urandom_range(4, 63));
                default: ;
            endcase
            set_ranges(lo, up, cnt);
            if (cnt >= 7'd3) fill_list(int'(cnt));

            n = $urandom_range(40, 160);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    offer_item(any_item(ACT_DRAW));
                end else if (r < 72) begin
                    item = any_item(ACT_SEED);
                    // hit the all-zero and all-one seeds now and then
                    if (r < 63) item.seed_value = r[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
                    offer_item(item);
                end else if (r < 90) begin
                    offer_item(any_item(ACT_WRITE));
                end else begin
                    offer_item(any_item(ActIgnored));
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/lrr_pkg.sv
hdl/lrr_ctrl.sv
hdl/lrr_dpath.sv
hdl/lcg_ranged_random_core.sv
sim/lrr_draw_checker.sv
sim/lcg_ranged_random_core_test.sv
